>>> hw/rtl/srrm_pkg.sv
// Shared types and codes for the suffix rank / range-minimum block.
// No dependencies; every other file of the block imports this package.
package srrm_pkg;

    // Width of one input symbol.
    localparam int SYM_W = 32;
    // Width of positions and bounds on the ports.
    localparam int POS_W = 11;

    // Input transaction payload.
    typedef struct packed {
        logic                    cmd;
        logic signed [SYM_W-1:0] symbol;
        logic                    last_symbol;
        logic [POS_W-1:0]        range_low;
        logic [POS_W-1:0]        range_high;
    } srrm_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [POS_W-1:0] start_position;
        logic             bad_query;
    } srrm_out_t;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Ordering rule applied by the shared compare unit.
    typedef enum logic [1:0] {
        CMP_SYMBOL,
        CMP_PAIR,
        CMP_NODE
    } cmp_op_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SENTINEL,
        ST_KEY_RD,
        ST_KEY_LATCH,
        ST_SCAN,
        ST_RANK_WR,
        ST_LEAF_RD,
        ST_LEAF_WR,
        ST_NODE_RD,
        ST_NODE_WR,
        ST_Q_CHECK,
        ST_Q_STEP,
        ST_Q_MERGE_L,
        ST_Q_MERGE_R,
        ST_Q_DONE
    } state_t;

endpackage

>>> hw/rtl/srrm_cmp.sv
// Shared compare unit: builds ordered keys for symbols, rank pairs or tree
// nodes and reports whether operand y orders strictly before operand x.
// Depends on srrm_pkg.
module srrm_cmp #(
    parameter int RW = 11
) (
    input  srrm_pkg::cmp_op_t         op,
    input  logic signed [31:0]        x_sym,
    input  logic [RW-1:0]             x_first,
    input  logic                      x_pres,
    input  logic [RW-1:0]             x_second,
    input  logic signed [31:0]        y_sym,
    input  logic [RW-1:0]             y_first,
    input  logic                      y_pres,
    input  logic [RW-1:0]             y_second,
    output logic                      y_less
);
    import srrm_pkg::*;

    localparam int KW = (2 * RW + 1 > 32) ? 2 * RW + 1 : 32;

    logic [KW-1:0] x_key;
    logic [KW-1:0] y_key;

    // Map each operand to an unsigned key; a missing second rank sorts first
    always_comb begin
        unique case (op)
            CMP_SYMBOL: begin
                x_key = KW'({~x_sym[31], x_sym[30:0]});
                y_key = KW'({~y_sym[31], y_sym[30:0]});
            end
            CMP_PAIR: begin
                x_key = KW'({x_first, x_pres, x_second});
                y_key = KW'({y_first, y_pres, y_second});
            end
            CMP_NODE: begin
                x_key = KW'({x_first, 1'b1, x_second});
                y_key = KW'({y_first, 1'b1, y_second});
            end
            default: begin
                x_key = '0;
                y_key = '0;
            end
        endcase
    end

    assign y_less = (y_key < x_key);

endmodule

>>> hw/rtl/srrm_rank_store.sv
// Symbol memory and the two banks of suffix ranks, with registered reads.
// Depends on srrm_pkg.
module srrm_rank_store #(
    parameter int MAX_LEN = 1024,
    parameter int AW      = 11
) (
    input  logic               aclk,
    input  logic               sym_we,
    input  logic [AW-1:0]      sym_waddr,
    input  logic signed [31:0] sym_wdata,
    input  logic [AW-1:0]      sym_raddr,
    output logic signed [31:0] sym_rdata,
    input  logic               rk_we,
    input  logic               rk_wbank,
    input  logic [AW-1:0]      rk_waddr,
    input  logic [AW-1:0]      rk_wdata,
    input  logic               rk_rbank,
    input  logic [AW-1:0]      rk_raddr_a,
    input  logic [AW-1:0]      rk_raddr_b,
    output logic [AW-1:0]      rk_rdata_a,
    output logic [AW-1:0]      rk_rdata_b
);
    import srrm_pkg::*;

    localparam int SDEPTH = MAX_LEN + 1;

    logic signed [31:0] sym_mem [SDEPTH];
    logic [AW-1:0]      rank_mem [2][SDEPTH];

    // Write and read the symbol memory
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        sym_rdata <= sym_mem[sym_raddr];
    end

    // Write one bank, read two entries of the other
    always_ff @(posedge aclk) begin
        if (rk_we) begin
            rank_mem[rk_wbank][rk_waddr] <= rk_wdata;
        end
        rk_rdata_a <= rank_mem[rk_rbank][rk_raddr_a];
        rk_rdata_b <= rank_mem[rk_rbank][rk_raddr_b];
    end

endmodule

>>> hw/rtl/srrm_tree_store.sv
// Min-tree memory of (rank, position) nodes, one write and two registered
// reads per cycle. Depends on srrm_pkg.
module srrm_tree_store #(
    parameter int MAX_LEN = 1024,
    parameter int TW      = 11,
    parameter int NW      = 22
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [TW-1:0] waddr,
    input  logic [NW-1:0] wdata,
    input  logic [TW-1:0] raddr_a,
    input  logic [TW-1:0] raddr_b,
    output logic [NW-1:0] rdata_a,
    output logic [NW-1:0] rdata_b
);
    import srrm_pkg::*;

    localparam int TDEPTH = 2 * MAX_LEN;

    logic [NW-1:0] tree_mem [TDEPTH];

    // Write one node, read two
    always_ff @(posedge aclk) begin
        if (we) begin
            tree_mem[waddr] <= wdata;
        end
        rdata_a <= tree_mem[raddr_a];
        rdata_b <= tree_mem[raddr_b];
    end

endmodule

>>> hw/rtl/suffix_rank_range_min.sv
// Channel | Dir | Signals              | Transaction
// s_      | in  | s_valid/s_ready/s_data | load one symbol or run a range query
// m_      | out | m_valid/m_ready/m_data | one result per query, none per load
//
// The last load ranks all L = n+1 suffixes (sentinel included) by prefix
// doubling on one shared compare unit in 1+ceil(log2(L)) passes, then builds
// the min tree. A query climbs the tree level by level, merging the boundary
// nodes of each level into the best node so far.
// Reset clears the sequencer, string length, built flag, pass flag, bank select
// and result valid; memories are not cleared. Input is held off while a result
// waits and a new one is ready.
// Depends on srrm_pkg, srrm_cmp, srrm_rank_store, srrm_tree_store.
module suffix_rank_range_min #(
    parameter int MAX_LEN = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srrm_pkg::srrm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srrm_pkg::srrm_out_t m_data
);
    import srrm_pkg::*;

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int LW = $clog2(MAX_LEN + 2);
    localparam int TW = $clog2(2 * MAX_LEN);
    localparam int NW = 2 * AW;

    state_t             state_reg, state_next;
    logic [AW-1:0]      n_reg, n_next;
    logic               built_reg, built_next;
    logic               pass0_reg, pass0_next;
    logic               cur_reg, cur_next;
    logic [LW-1:0]      i_reg, i_next;
    logic [LW-1:0]      j_reg, j_next;
    logic [LW-1:0]      k_reg, k_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               pres_rd_reg;
    logic signed [31:0] ksym_reg, ksym_next;
    logic [AW-1:0]      kfirst_reg, kfirst_next;
    logic [AW-1:0]      ksecond_reg, ksecond_next;
    logic               kpres_reg, kpres_next;
    logic [TW:0]        t_reg, t_next;
    logic [TW:0]        l_reg, l_next;
    logic [TW:0]        r_reg, r_next;
    logic               take_l_reg, take_l_next;
    logic               take_r_reg, take_r_next;
    logic [NW-1:0]      best_reg, best_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    srrm_out_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    srrm_out_t          m_data_reg, m_data_next;

    logic [LW-1:0]      len;
    logic [LW-1:0]      rd_idx;
    logic [LW:0]        rd_sum;
    logic               rd_pres;

    logic               sym_we;
    logic [AW-1:0]      sym_waddr;
    logic signed [31:0] sym_wdata;
    logic signed [31:0] sym_rdata;
    logic               rk_we;
    logic [AW-1:0]      rk_raddr_a;
    logic [AW-1:0]      rk_raddr_b;
    logic [AW-1:0]      rk_rdata_a;
    logic [AW-1:0]      rk_rdata_b;

    logic               tr_we;
    logic [TW-1:0]      tr_waddr;
    logic [NW-1:0]      tr_wdata;
    logic [TW-1:0]      tr_raddr_a;
    logic [TW-1:0]      tr_raddr_b;
    logic [NW-1:0]      tr_rdata_a;
    logic [NW-1:0]      tr_rdata_b;

    cmp_op_t            c_op;
    logic signed [31:0] c_x_sym;
    logic [AW-1:0]      c_x_first, c_x_second;
    logic               c_x_pres;
    logic [AW-1:0]      c_y_first, c_y_second;
    logic               c_y_pres;
    logic               c_y_less;

    logic [AW-1:0]      load_base;
    logic [LW:0]        k_dbl;

    srrm_rank_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_rank_store (
        .aclk       (aclk),
        .sym_we     (sym_we),
        .sym_waddr  (sym_waddr),
        .sym_wdata  (sym_wdata),
        .sym_raddr  (rd_idx[AW-1:0]),
        .sym_rdata  (sym_rdata),
        .rk_we      (rk_we),
        .rk_wbank   (~cur_reg),
        .rk_waddr   (i_reg[AW-1:0]),
        .rk_wdata   (cnt_reg),
        .rk_rbank   (cur_reg),
        .rk_raddr_a (rk_raddr_a),
        .rk_raddr_b (rk_raddr_b),
        .rk_rdata_a (rk_rdata_a),
        .rk_rdata_b (rk_rdata_b)
    );

    srrm_tree_store #(
        .MAX_LEN (MAX_LEN),
        .TW      (TW),
        .NW      (NW)
    ) u_tree_store (
        .aclk    (aclk),
        .we      (tr_we),
        .waddr   (tr_waddr),
        .wdata   (tr_wdata),
        .raddr_a (tr_raddr_a),
        .raddr_b (tr_raddr_b),
        .rdata_a (tr_rdata_a),
        .rdata_b (tr_rdata_b)
    );

    srrm_cmp #(
        .RW (AW)
    ) u_cmp (
        .op       (c_op),
        .x_sym    (c_x_sym),
        .x_first  (c_x_first),
        .x_pres   (c_x_pres),
        .x_second (c_x_second),
        .y_sym    (sym_rdata),
        .y_first  (c_y_first),
        .y_pres   (c_y_pres),
        .y_second (c_y_second),
        .y_less   (c_y_less)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Suffix count with sentinel, and the doubled-offset read address
    assign len     = LW'(n_reg) + LW'(1);
    assign rd_idx  = (state_reg == ST_SCAN) ? j_reg : i_reg;
    assign rd_sum  = {1'b0, rd_idx} + {1'b0, k_reg};
    assign rd_pres = (rd_sum < {1'b0, len});
    assign k_dbl   = {k_reg, 1'b0};

    // Rank read ports: leaf fill reads one rank, ranking reads a pair
    assign rk_raddr_a = (state_reg == ST_LEAF_RD) ? t_reg[AW-1:0] : rd_idx[AW-1:0];
    assign rk_raddr_b = rd_pres ? rd_sum[AW-1:0] : '0;

    // Tree read ports: two children on build, two boundary nodes on query
    always_comb begin
        if (state_reg == ST_NODE_RD) begin
            tr_raddr_a = TW'({t_reg, 1'b0});
            tr_raddr_b = TW'({t_reg, 1'b1});
        end else begin
            tr_raddr_a = l_reg[TW-1:0];
            tr_raddr_b = TW'(r_reg - (TW+1)'(1));
        end
    end

    // Steer operands into the shared compare unit
    always_comb begin
        c_x_sym    = ksym_reg;
        c_x_first  = kfirst_reg;
        c_x_pres   = kpres_reg;
        c_x_second = ksecond_reg;
        c_y_first  = rk_rdata_a;
        c_y_pres   = pres_rd_reg;
        c_y_second = rk_rdata_b;
        c_op       = pass0_reg ? CMP_SYMBOL : CMP_PAIR;
        unique case (state_reg)
            ST_NODE_WR: begin
                c_op       = CMP_NODE;
                c_x_first  = tr_rdata_a[NW-1:AW];
                c_x_second = tr_rdata_a[AW-1:0];
                c_y_first  = tr_rdata_b[NW-1:AW];
                c_y_second = tr_rdata_b[AW-1:0];
            end
            ST_Q_MERGE_L: begin
                c_op       = CMP_NODE;
                c_x_first  = best_reg[NW-1:AW];
                c_x_second = best_reg[AW-1:0];
                c_y_first  = tr_rdata_a[NW-1:AW];
                c_y_second = tr_rdata_a[AW-1:0];
            end
            ST_Q_MERGE_R: begin
                c_op       = CMP_NODE;
                c_x_first  = best_reg[NW-1:AW];
                c_x_second = best_reg[AW-1:0];
                c_y_first  = tr_rdata_b[NW-1:AW];
                c_y_second = tr_rdata_b[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Sequencer: next state, counters and memory writes
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        built_next   = built_reg;
        pass0_next   = pass0_reg;
        cur_next     = cur_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        ksym_next    = ksym_reg;
        kfirst_next  = kfirst_reg;
        ksecond_next = ksecond_reg;
        kpres_next   = kpres_reg;
        t_next       = t_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        take_l_next  = take_l_reg;
        take_r_next  = take_r_reg;
        best_next    = best_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        sym_we       = 1'b0;
        sym_waddr    = n_reg;
        sym_wdata    = s_data.symbol;
        rk_we        = 1'b0;
        tr_we        = 1'b0;
        tr_waddr     = t_reg[TW-1:0];
        tr_wdata     = tr_rdata_a;
        load_base    = built_reg ? '0 : n_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.cmd == CMD_LOAD) begin
                        built_next = 1'b0;
                        n_next     = load_base;
                        if (32'(load_base) < 32'(MAX_LEN)) begin
                            sym_we    = 1'b1;
                            sym_waddr = load_base;
                            n_next    = load_base + AW'(1);
                        end
                        if (s_data.last_symbol) begin
                            state_next = ST_SENTINEL;
                        end
                    end else begin
                        lo_next    = s_data.range_low;
                        hi_next    = s_data.range_high;
                        state_next = ST_Q_CHECK;
                    end
                end
            end
            ST_SENTINEL: begin
                // Append the zero sentinel, start the symbol ranking pass
                sym_we     = 1'b1;
                sym_waddr  = n_reg;
                sym_wdata  = '0;
                pass0_next = 1'b1;
                i_next     = '0;
                k_next     = '0;
                state_next = ST_KEY_RD;
            end
            ST_KEY_RD: begin
                state_next = ST_KEY_LATCH;
            end
            ST_KEY_LATCH: begin
                // Hold the key of suffix i for the whole scan
                ksym_next    = sym_rdata;
                kfirst_next  = rk_rdata_a;
                ksecond_next = rk_rdata_b;
                kpres_next   = pres_rd_reg;
                j_next       = '0;
                cnt_next     = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                // Count suffixes ordered strictly before suffix i
                if (j_reg != '0 && c_y_less) begin
                    cnt_next = cnt_reg + AW'(1);
                end
                j_next = j_reg + LW'(1);
                if (j_reg == len) begin
                    state_next = ST_RANK_WR;
                end
            end
            ST_RANK_WR: begin
                rk_we  = 1'b1;
                i_next = i_reg + LW'(1);
                if (i_reg + LW'(1) == len) begin
                    // End of pass: swap banks and set the next offset (1 after the symbol pass, then doubled)
                    cur_next   = ~cur_reg;
                    pass0_next = 1'b0;
                    i_next     = '0;
                    if (pass0_reg) begin
                        k_next     = LW'(1);
                        state_next = ST_KEY_RD;
                    end else begin
                        k_next = LW'(k_dbl);
                        if (k_dbl < {1'b0, len}) begin
                            state_next = ST_KEY_RD;
                        end else begin
                            t_next     = '0;
                            state_next = ST_LEAF_RD;
                        end
                    end
                end else begin
                    state_next = ST_KEY_RD;
                end
            end
            ST_LEAF_RD: begin
                state_next = ST_LEAF_WR;
            end
            ST_LEAF_WR: begin
                // Fill one leaf; leaves past the string get the max node
                tr_we    = 1'b1;
                tr_waddr = TW'(t_reg + (TW+1)'(MAX_LEN));
                if (t_reg < (TW+1)'(n_reg)) begin
                    tr_wdata = {rk_rdata_a, AW'(t_reg + (TW+1)'(1))};
                end else begin
                    tr_wdata = '1;
                end
                if (t_reg == (TW+1)'(MAX_LEN - 1)) begin
                    state_next = ST_NODE_RD;
                end else begin
                    t_next     = t_reg + (TW+1)'(1);
                    state_next = ST_LEAF_RD;
                end
            end
            ST_NODE_RD: begin
                state_next = ST_NODE_WR;
            end
            ST_NODE_WR: begin
                // Store the smaller child; the left one wins a tie
                tr_we    = 1'b1;
                tr_waddr = t_reg[TW-1:0];
                tr_wdata = c_y_less ? tr_rdata_b : tr_rdata_a;
                if (t_reg == (TW+1)'(1)) begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    t_next     = t_reg - (TW+1)'(1);
                    state_next = ST_NODE_RD;
                end
            end
            ST_Q_CHECK: begin
                if (!built_reg || lo_reg == '0 || 32'(hi_reg) > 32'(n_reg)
                        || lo_reg > hi_reg) begin
                    res_next.start_position = '0;
                    res_next.bad_query      = 1'b1;
                    state_next              = ST_Q_DONE;
                end else begin
                    l_next     = (TW+1)'(lo_reg) + (TW+1)'(MAX_LEN - 1);
                    r_next     = (TW+1)'(hi_reg) + (TW+1)'(MAX_LEN);
                    best_next  = '1;
                    state_next = ST_Q_STEP;
                end
            end
            ST_Q_STEP: begin
                // Fetch the boundary nodes that drop out of this level
                if (l_reg < r_reg) begin
                    take_l_next = l_reg[0];
                    take_r_next = r_reg[0];
                    state_next  = ST_Q_MERGE_L;
                end else begin
                    res_next.start_position = POS_W'(best_reg[AW-1:0]);
                    res_next.bad_query      = 1'b0;
                    state_next              = ST_Q_DONE;
                end
            end
            ST_Q_MERGE_L: begin
                if (take_l_reg && c_y_less) begin
                    best_next = tr_rdata_a;
                end
                state_next = ST_Q_MERGE_R;
            end
            ST_Q_MERGE_R: begin
                // Merge the right node, then climb one level
                if (take_r_reg && c_y_less) begin
                    best_next = tr_rdata_b;
                end
                l_next     = (l_reg + (TW+1)'(take_l_reg)) >> 1;
                r_next     = (r_reg - (TW+1)'(take_r_reg)) >> 1;
                state_next = ST_Q_STEP;
            end
            ST_Q_DONE: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            built_reg   <= 1'b0;
            pass0_reg   <= 1'b0;
            cur_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            built_reg   <= built_next;
            pass0_reg   <= pass0_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        pres_rd_reg <= rd_pres;
        ksym_reg    <= ksym_next;
        kfirst_reg  <= kfirst_next;
        ksecond_reg <= ksecond_next;
        kpres_reg   <= kpres_next;
        t_reg       <= t_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        take_l_reg  <= take_l_next;
        take_r_reg  <= take_r_next;
        best_reg    <= best_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

endmodule

>>> tb/suffix_rank_range_min_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for suffix_rank_range_min: directed table, one full-capacity
// string, then random strings and queries checked against a suffix-ranking predictor.
// Depends on srrm_pkg and the suffix_rank_range_min RTL.
module suffix_rank_range_min_tb;
    import srrm_pkg::*;

    localparam int MAX_LEN     = 1024;
    localparam int ITEM_TARGET = 1350;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        srrm_in_t  item;
        bit        fixed;
        srrm_out_t answer;
    } table_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    srrm_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    srrm_out_t m_data;

    // Predictor state
    longint    sym_mem [0:MAX_LEN];
    longint    rank_mem [0:MAX_LEN];
    int        order_mem [0:MAX_LEN];
    int        scratch_mem [0:MAX_LEN];
    int        sym_count = 0;
    bit        built = 1'b0;

    srrm_out_t answer_q [$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        queries_sent = 0;
    int        builds_done = 0;
    int        answers_seen = 0;
    int        send_idle_pct = 38;
    int        recv_idle_pct = 77;
    longint    cycle_count = 0;

    suffix_rank_range_min #(.MAX_LEN(MAX_LEN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Strict order of two suffixes at doubling step k
    function automatic bit suffix_before(int a, int b, int k, int len);
        if (rank_mem[a] != rank_mem[b]) return rank_mem[a] < rank_mem[b];
        if (a + k < len && b + k < len) return rank_mem[a + k] < rank_mem[b + k];
        return a > b;
    endfunction

    // Rank all suffixes of the stored string plus zero sentinel
    task automatic rank_suffixes();
        int len, i, j, k, v;
        len = sym_count + 1;
        sym_mem[sym_count] = 0;
        for (i = 0; i < len; i++) begin
            rank_mem[i] = sym_mem[i];
            order_mem[i] = i;
        end
        for (k = 1; k < len; k = k << 1) begin
            for (i = 1; i < len; i++) begin
                v = order_mem[i];
                j = i;
                while (j > 0 && suffix_before(v, order_mem[j-1], k, len)) begin
                    order_mem[j] = order_mem[j-1];
                    j--;
                end
                order_mem[j] = v;
            end
            scratch_mem[0] = 0;
            for (i = 1; i < len; i++)
                scratch_mem[i] = scratch_mem[i-1] +
                    (suffix_before(order_mem[i-1], order_mem[i], k, len) ? 1 : 0);
            for (i = 0; i < len; i++) rank_mem[order_mem[i]] = scratch_mem[i];
            if (scratch_mem[len-1] == len - 1) break;
        end
        built = 1'b1;
        builds_done++;
    endtask

    // Lowest-ranked start position in a range, or the error result
    function automatic srrm_out_t lowest_suffix(int lo, int hi);
        srrm_out_t r;
        longint best;
        int p;
        r = '0;
        if (!built || lo == 0 || hi > sym_count || lo > hi) begin
            r.bad_query = 1'b1;
            return r;
        end
        best = 64'h7FFF_FFFF_FFFF_FFFF;
        for (p = lo; p <= hi; p++)
            if (rank_mem[p-1] < best) begin
                best = rank_mem[p-1];
                r.start_position = POS_W'(p);
            end
        return r;
    endfunction

    // Apply an accepted transaction to the predictor
    task automatic absorb(srrm_in_t it, bit fixed, srrm_out_t fixed_ans);
        srrm_out_t pred;
        if (it.cmd == CMD_LOAD) begin
            if (built) begin
                built = 1'b0;
                sym_count = 0;
            end
            if (sym_count < MAX_LEN) begin
                sym_mem[sym_count] = longint'(it.symbol);
                sym_count++;
            end
            if (it.last_symbol) rank_suffixes();
        end else begin
            pred = lowest_suffix(int'(it.range_low), int'(it.range_high));
            if (fixed && pred != fixed_ans) begin
                $display("%0t table row disagrees with predictor: expected %0d/%0b got %0d/%0b",
                         $realtime, fixed_ans.start_position, fixed_ans.bad_query,
                         pred.start_position, pred.bad_query);
                fail_count++;
            end
            answer_q.push_back(fixed ? fixed_ans : pred);
            queries_sent++;
        end
    endtask

    // Present one transaction and hold it until accepted
    task automatic send(srrm_in_t it, bit fixed = 1'b0, srrm_out_t fixed_ans = '0);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb(it, fixed, fixed_ans);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic srrm_in_t load_item(logic signed [31:0] sym, bit last);
        srrm_in_t it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.symbol = sym;
        it.last_symbol = last;
        it.range_low = POS_W'($urandom);
        it.range_high = POS_W'($urandom);
        return it;
    endfunction

    function automatic srrm_in_t query_item(int lo, int hi);
        srrm_in_t it;
        it = '0;
        it.cmd = CMD_QUERY;
        it.symbol = $urandom;
        it.last_symbol = $urandom_range(1);
        it.range_low = POS_W'(lo);
        it.range_high = POS_W'(hi);
        return it;
    endfunction

    function automatic logic signed [31:0] pick_symbol();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(4)) - 2;
        endcase
    endfunction

    // Track idling mode from progress
    always @(posedge aclk) begin
        if (items_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 38;
            recv_idle_pct = 77;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 77;
            recv_idle_pct = 38;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Check results and randomize the receiver's readiness
    always @(posedge aclk) begin
        srrm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            answers_seen++;
            if (answer_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %0d/%0b",
                         $realtime, m_data.start_position, m_data.bad_query);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                if (m_data.start_position !== want.start_position)
                    begin
                    $display("%0t start_position mismatch: expected %0d actual %0d",
                             $realtime, want.start_position, m_data.start_position);
                    fail_count++;
                end
                if (m_data.bad_query !== want.bad_query) begin
                    $display("%0t bad_query mismatch: expected %0b actual %0b",
                             $realtime, want.bad_query, m_data.bad_query);
                    fail_count++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, answer_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        table_row_t rows [$];
        srrm_out_t bad, at;
        int i, n, lo, hi, kind;

        bad = '0;
        bad.bad_query = 1'b1;
        rows.push_back('{query_item(1, 1), 1'b1, bad});           // nothing built
        rows.push_back('{load_item(5, 0), 1'b0, '0});
        rows.push_back('{load_item(32'sh8000_0000, 0), 1'b0, '0});
        rows.push_back('{load_item(32'sh7FFF_FFFF, 0), 1'b0, '0});
        rows.push_back('{load_item(0, 1), 1'b0, '0});
        rows.push_back('{query_item(1, 4), 1'b0, '0});
        rows.push_back('{query_item(3, 4), 1'b0, '0});
        rows.push_back('{query_item(0, 1), 1'b1, bad});           // zero low bound
        rows.push_back('{query_item(3, 2), 1'b1, bad});           // reversed bounds
        rows.push_back('{query_item(1, 5), 1'b1, bad});           // past the string
        rows.push_back('{query_item(2047, 2047), 1'b1, bad});
        at = '0;
        at.start_position = 2;
        rows.push_back('{query_item(2, 2), 1'b1, at});
        rows.push_back('{load_item(-1, 1), 1'b0, '0});            // restart after build
        at.start_position = 1;
        rows.push_back('{query_item(1, 1), 1'b1, at});
        rows.push_back('{query_item(1, 2), 1'b1, bad});
        rows.push_back('{load_item(3, 0), 1'b0, '0});
        rows.push_back('{query_item(1, 1), 1'b1, bad});           // string being loaded
        rows.push_back('{load_item(3, 1), 1'b0, '0});
        rows.push_back('{query_item(1, 2), 1'b0, '0});
        rows.push_back('{query_item(2, 2), 1'b0, '0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (rows[r]) send(rows[r].item, rows[r].fixed, rows[r].answer);

        // Fill past capacity; the overflow symbol carries the last flag
        for (i = 0; i <= MAX_LEN; i++)
            send(load_item($signed($urandom_range(2)) - 1, i == MAX_LEN));
        send(query_item(1, MAX_LEN));
        at.start_position = MAX_LEN;
        send(query_item(MAX_LEN, MAX_LEN), 1'b1, at);
        send(query_item(MAX_LEN + 1, MAX_LEN + 1), 1'b1, bad);
        send(query_item(1, MAX_LEN + 1), 1'b1, bad);

        // Random strings followed by queries, mixed with noise
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(9);
            if (kind < 8) begin
                n = $urandom_range(24, 1);
                for (i = 0; i < n; i++) send(load_item(pick_symbol(), i == n - 1));
                repeat ($urandom_range(8, 2)) begin
                    if ($urandom_range(9) < 8) begin
                        lo = $urandom_range(sym_count, 1);
                        hi = $urandom_range(sym_count, lo);
                    end else begin
                        lo = $urandom_range(2047);
                        hi = $urandom_range(2047);
                    end
                    send(query_item(lo, hi));
                end
            end else if (kind == 8 && sym_count < 24) begin
                send(load_item($urandom, 1'b0));
            end else begin
                send(query_item($urandom_range(2047), $urandom_range(2047)));
            end
        end
        s_valid <= 1'b0;

        while (answer_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d transactions: %0d queries, %0d string builds (one at full capacity).",
                 items_sent, queries_sent, builds_done);
        $display("Checked %0d results under three sender/receiver idling mixes.", answers_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/srrm_pkg.sv
hw/rtl/srrm_cmp.sv
hw/rtl/srrm_rank_store.sv
hw/rtl/srrm_tree_store.sv
hw/rtl/suffix_rank_range_min.sv
tb/suffix_rank_range_min_tb.sv
